// File: src/flc_pkg.sv
// Shared types and constants for the FIFO TTL lookup cache.
package flc_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int TTL_W  = 31;
  localparam int TIME_W = 32;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 64;

  typedef enum logic {
    MODE_SEARCH = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_HIT_VAL   = 3'd2,
    ST_HIT_NOVAL = 3'd3,
    ST_STORED    = 3'd4,
    ST_REFUSED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_ROT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic                  valid;
    logic                  has_value;
    logic [TIME_W-1:0]     stamp;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  typedef struct packed {
    mode_t             mode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;
    logic              value_present;
    logic [TIME_W-1:0] now;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value_out;
  } out_rsp_t;

endpackage

// File: src/fifo_ttl_lookup_cache.sv
// Top level: FIFO-replacement key/value cache with time-to-live, built as a ring of slot cells.
//
// Requests arrive on in_valid/in_stall/in_data and results leave on out_valid/out_stall/
// out_data; a request or result moves at an edge with valid high and stall low. Exactly
// one result per request. cfg_we/cfg_wdata write the 31-bit ttl; the user must do so only
// while the block is idle, which the block does not enforce. Cell 0 holds the newest entry,
// the last cell the oldest. Update: the oldest entry is checked at the tail cell; if allowed
// the chain shifts by one and the new entry enters at cell 0. The result is registered
// at acceptance; one update a cycle while the receiver does not stall. Search: the ring rotates
// one cell a cycle past a comparator at cell 0, newest first, and completes a full turn to
// restore order before the result is registered; a new request waits until the search ends.
// A request is taken only when the sequencer is idle and the result register is free or
// being emptied; while the receiver stalls the result holds and new requests wait.
// Reset (synchronous, rst_n low) clears ttl, all valid bits and timestamps at once; there
// is no clearing pass.
module fifo_ttl_lookup_cache import flc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_rsp_t         out_data,
  input  logic             cfg_we,
  input  logic [TTL_W-1:0] cfg_wdata
);

  cell_op_t op;
  slot_t    push_slot;
  slot_t    cell_q [ENTRIES];

  flc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head_slot (cell_q[0]),
    .tail_slot (cell_q[ENTRIES-1]),
    .op        (op),
    .push_slot (push_slot)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    slot_t prev_in;
    slot_t next_in;

    if (i == 0) begin : g_first
      assign prev_in = push_slot;
    end else begin : g_mid_prev
      assign prev_in = cell_q[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign next_in = cell_q[0];
    end else begin : g_mid_next
      assign next_in = cell_q[i+1];
    end

    flc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .prev_slot (prev_in),
      .next_slot (next_in),
      .q         (cell_q[i])
    );
  end

endmodule

// File: src/flc_cell.sv
// One slot of the chain: holds an entry, takes a push from below or a rotate from above.
module flc_cell import flc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cell_op_t op,
  input  slot_t    prev_slot,
  input  slot_t    next_slot,
  output slot_t    q
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    unique case (op)
      OP_HOLD: slot_nxt = slot_r;
      OP_PUSH: slot_nxt = prev_slot;
      OP_ROT:  slot_nxt = next_slot;
      default: slot_nxt = slot_r;
    endcase
  end

  // key and value need no reset: only read behind a valid entry
  always_ff @(posedge clk) begin
    slot_r.key   <= slot_nxt.key;
    slot_r.value <= slot_nxt.value;
    if (!rst_n) begin
      slot_r.valid     <= 1'b0;
      slot_r.has_value <= 1'b0;
      slot_r.stamp     <= '0;
    end else begin
      slot_r.valid     <= slot_nxt.valid;
      slot_r.has_value <= slot_nxt.has_value;
      slot_r.stamp     <= slot_nxt.stamp;
    end
  end

  assign q = slot_r;

endmodule

// File: src/flc_ctrl.sv
// Request sequencer: update check at the tail cell, search compare at the head cell, result register.
module flc_ctrl import flc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_rsp_t         out_data,
  input  logic             cfg_we,
  input  logic [TTL_W-1:0] cfg_wdata,
  input  slot_t            head_slot,
  input  slot_t            tail_slot,
  output cell_op_t         op,
  output slot_t            push_slot
);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_r, out_nxt;
  logic [TTL_W-1:0]    ttl_r, ttl_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                found_r, found_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;

  logic              in_acc;
  logic              out_free;
  logic              is_update;
  logic              tail_back;
  logic [TIME_W-1:0] tail_age;
  logic              refuse;
  logic              head_back;
  logic [TIME_W-1:0] head_age;
  logic              expired;
  logic              hit;
  out_rsp_t          hit_rsp;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == S_IDLE && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign is_update = (in_data.mode == MODE_UPDATE);

  // age is unsigned: a stamp ahead of now is caught by a separate compare, never expires and always refuses
  assign tail_back = in_data.now < tail_slot.stamp;
  assign tail_age  = in_data.now - tail_slot.stamp;
  assign refuse    = tail_back || (tail_age < TIME_W'(ttl_r));

  assign head_back = now_r < head_slot.stamp;
  assign head_age  = now_r - head_slot.stamp;
  assign expired   = !head_back && (head_age > TIME_W'(ttl_r));
  assign hit       = !found_r && head_slot.valid && (head_slot.key == key_r);

  always_comb begin
    hit_rsp.value_out = '0;
    if (expired) begin
      hit_rsp.status = ST_EXPIRED;
    end else if (head_slot.has_value) begin
      hit_rsp.status    = ST_HIT_VAL;
      hit_rsp.value_out = VAL_W'(head_slot.value);
    end else begin
      hit_rsp.status = ST_HIT_NOVAL;
    end
  end

  always_comb begin
    push_slot.valid     = 1'b1;
    push_slot.has_value = in_data.value_present;
    push_slot.stamp     = in_data.now;
    push_slot.key       = in_data.key[KEY_BITS-1:0];
    push_slot.value     = in_data.value_present ? in_data.value_in[VALUE_BITS-1:0] : '0;
  end

  always_comb begin
    if (in_acc && is_update && !refuse) begin
      op = OP_PUSH;
    end else if (state_r == S_SEARCH) begin
      op = OP_ROT;
    end else begin
      op = OP_HOLD;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ttl_nxt       = ttl_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    now_nxt       = now_r;

    if (cfg_we) begin
      ttl_nxt = cfg_wdata;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (is_update) begin
            out_valid_nxt     = 1'b1;
            out_nxt.status    = refuse ? ST_REFUSED : ST_STORED;
            out_nxt.value_out = '0;
          end else begin
            state_nxt         = S_SEARCH;
            key_nxt           = in_data.key[KEY_BITS-1:0];
            now_nxt           = in_data.now;
            cnt_nxt           = '0;
            found_nxt         = 1'b0;
            out_nxt.status    = ST_MISS;
            out_nxt.value_out = '0;
          end
        end
      end
      S_SEARCH: begin
        // newest entry sits at the head; the ring turns once per search request
        if (hit) begin
          found_nxt = 1'b1;
          out_nxt   = hit_rsp;
        end
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ttl_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ttl_r       <= ttl_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      out_r       <= out_nxt;
      key_r       <= key_nxt;
      now_r       <= now_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_search_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> !out_valid_r)
    else $error("result pending during search");

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_update |=> out_valid_r &&
      (out_r.status == ST_STORED || out_r.status == ST_REFUSED))
    else $error("update gave no store/refuse result");

  a_search_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_update |=> state_r == S_SEARCH && cnt_r == '0 && !found_r)
    else $error("search did not start cleanly");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_HIT_VAL |-> out_r.value_out == '0)
    else $error("value returned without a valued hit");

  a_no_push_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> op == OP_ROT)
    else $error("chain not rotating during search");

endmodule
